@@ sv/fsrs_pkg.sv @@
// Package for the fixed-rate sample scheduler.
// Mode codes, fixed field widths and the divider status type.
// No dependencies.
package fsrs_pkg;

    localparam int IV_BITS  = 32;
    localparam int OUT_BITS = 32;

    localparam logic [IV_BITS-1:0]  INTERVAL_RESET = 32'd16666667;
    localparam logic [OUT_BITS-1:0] OUT_MAX        = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_QUERY   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ sv/fixed_rate_sample_scheduler_core.sv @@
// Fixed-rate sample scheduler: sequencer, schedule state and output register.
// Depends on fsrs_pkg and fsrs_div.
//
// channel   direction  accept                      payload
// s_axis    in         tvalid & tready             tuser = mode, tdata = time_now
// m_axis    out        tvalid & tready             tuser = due, tdata = counts
// cfg       in         cfg_wr_en                   cfg_wr_data = interval_ns
//
// Query and restart run compare and output; a sample runs compare, late check,
// the bit-serial divider if late (one quotient bit a cycle), advance, update, output.
// Reset clears the schedule (not started, counters zero) and sets interval_ns.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile and stalls only at its own output step.
module fixed_rate_sample_scheduler_core #(
    parameter int TIME_BITS  = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // time_now[63:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // frame_index[31:0], dropped_now[63:32],
                                        // dropped_total[95:64]
    output logic        m_axis_tuser    // due
);
    import fsrs_pkg::*;

    localparam int QW = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
    localparam int CW = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_LATE,
        ST_DIV,
        ST_ADV,
        ST_UPD,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [IV_BITS-1:0]    interval_reg;
    logic [IV_BITS-1:0]    iv_reg;
    logic [TIME_BITS-1:0]  t_reg;
    logic [1:0]            mode_reg;
    logic [TIME_BITS-1:0]  nd_reg;
    logic [COUNT_BITS-1:0] fc_reg;
    logic [COUNT_BITS-1:0] dc_reg;
    logic                  started_reg;
    logic                  due_reg;
    logic [COUNT_BITS-1:0] idx_reg;
    logic [COUNT_BITS-1:0] dnow_reg;
    logic                  m_valid_reg;
    logic [95:0]           m_data_reg;
    logic                  m_user_reg;

    logic [TIME_BITS:0]    diff;
    logic                  late;
    logic                  div_start;
    div_status_t           div_status;
    logic [TIME_BITS-1:0]  div_q;
    logic [IV_BITS-1:0]    div_r;
    logic [QW-1:0]         q_ext;
    logic [COUNT_BITS-1:0] q_sat;
    logic [COUNT_BITS-1:0] dc_next;
    logic [COUNT_BITS-1:0] fc_next;
    logic                  out_load;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        return (ve > CW'(OUT_MAX)) ? OUT_MAX : ve[OUT_BITS-1:0];
    endfunction

    assign diff      = {1'b0, t_reg} - {1'b0, nd_reg};
    assign late      = ~diff[TIME_BITS] && (diff[TIME_BITS-1:0] != '0);
    assign div_start = (state_reg == ST_LATE) && late;
    assign q_ext     = QW'(div_q);
    assign q_sat     = (q_ext > QW'(COUNT_MAX)) ? COUNT_MAX : q_ext[COUNT_BITS-1:0];
    assign dc_next   = sat_add(dc_reg, dnow_reg);
    assign fc_next   = sat_add(fc_reg, COUNT_BITS'(1));
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    fsrs_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (diff[TIME_BITS-1:0]),
        .divisor   (iv_reg),
        .status    (div_status),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            interval_reg <= INTERVAL_RESET;
            iv_reg       <= '0;
            t_reg        <= '0;
            mode_reg     <= MODE_QUERY;
            nd_reg       <= '0;
            fc_reg       <= '0;
            dc_reg       <= '0;
            started_reg  <= 1'b0;
            due_reg      <= 1'b0;
            idx_reg      <= '0;
            dnow_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_user_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end

            if (m_valid_reg && m_axis_tready && !out_load)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        t_reg     <= s_axis_tdata[TIME_BITS-1:0];
                        mode_reg  <= s_axis_tuser;
                        iv_reg    <= (interval_reg == '0) ? IV_BITS'(1) : interval_reg;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    due_reg  <= started_reg && (t_reg >= nd_reg);
                    dnow_reg <= '0;
                    if (mode_reg == MODE_SAMPLE)
                    begin
                        if (!started_reg)
                        begin
                            nd_reg      <= t_reg;
                            fc_reg      <= '0;
                            dc_reg      <= '0;
                            started_reg <= 1'b1;
                        end
                        state_reg <= ST_LATE;
                    end
                    else if (mode_reg == MODE_RESTART)
                    begin
                        nd_reg      <= t_reg;
                        fc_reg      <= '0;
                        dc_reg      <= '0;
                        started_reg <= 1'b1;
                        idx_reg     <= '0;
                        state_reg   <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg   <= fc_reg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_LATE:
                begin
                    if (late)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        t_reg     <= nd_reg;
                        state_reg <= ST_ADV;
                    end
                end
                ST_DIV:
                begin
                    if (div_status.done)
                    begin
                        dnow_reg  <= q_sat;
                        t_reg     <= t_reg - TIME_BITS'(div_r);
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV:
                begin
                    nd_reg    <= t_reg + TIME_BITS'(iv_reg);
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    dc_reg    <= dc_next;
                    idx_reg   <= fc_reg;
                    fc_reg    <= fc_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_data_reg  <= {clamp_out(dc_reg), clamp_out(dnow_reg),
                                        clamp_out(idx_reg)};
                        m_user_reg  <= due_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/fsrs_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Divides a TIME_BITS-wide dividend by a 32-bit divisor.
// Depends on fsrs_pkg.
module fsrs_div #(
    parameter int TIME_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [TIME_BITS-1:0]        dividend,
    input  logic [fsrs_pkg::IV_BITS-1:0] divisor,
    output fsrs_pkg::div_status_t       status,
    output logic [TIME_BITS-1:0]        quotient,
    output logic [fsrs_pkg::IV_BITS-1:0] remainder
);
    import fsrs_pkg::*;

    localparam int CNT_BITS = $clog2(TIME_BITS + 1);

    logic [TIME_BITS-1:0] qd_reg;
    logic [IV_BITS-1:0]   rem_reg;
    logic [IV_BITS-1:0]   dsr_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [IV_BITS:0] shifted;
    logic [IV_BITS:0] trial;
    logic             ge;

    assign shifted = {rem_reg, qd_reg[TIME_BITS-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign ge      = ~trial[IV_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_BITS'(TIME_BITS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[IV_BITS-1:0] : shifted[IV_BITS-1:0];
            qd_reg  <= {qd_reg[TIME_BITS-2:0], ge};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = qd_reg;
    assign remainder   = rem_reg;

endmodule
